// ===== sv/dohp_pkg.sv =====
// ----------------------------------------------------------------------------
// dohp_pkg
// Types, codes and string constants shared by the request header parser.
// ----------------------------------------------------------------------------
package dohp_pkg;

    // Header byte counter width, enough for the largest header limit
    localparam int HC_W = 14;

    // Verdict status codes
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_REQUEST = 4'd1,
        ST_NOT_FOUND   = 4'd2,
        ST_METHOD      = 4'd3,
        ST_LENGTH_REQ  = 4'd4,
        ST_TOO_LARGE   = 4'd5,
        ST_URI_LONG    = 4'd6,
        ST_MEDIA       = 4'd7,
        ST_HEADER_BIG  = 4'd8,
        ST_VERSION     = 4'd9
    } t_status;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_METHOD  = 7'b0000001,
        PH_TARGET  = 7'b0000010,
        PH_VERSION = 7'b0000100,
        PH_HNAME   = 7'b0001000,
        PH_HVALUE  = 7'b0010000,
        PH_BODY    = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    // Kind of the header line being parsed
    typedef enum logic [1:0] {
        HK_NONE  = 2'd0,
        HK_CTYPE = 2'd1,
        HK_CLEN  = 2'd2
    } t_hkind;

    // Configuration register indexes
    localparam logic [1:0] CFG_PATH_LOW  = 2'd0;
    localparam logic [1:0] CFG_PATH_HIGH = 2'd1;
    localparam logic [1:0] CFG_PATH_LEN  = 2'd2;

    // Match flag bit positions
    localparam int MF_POST  = 0;
    localparam int MF_PATH  = 1;
    localparam int MF_V11   = 2;
    localparam int MF_V10   = 3;
    localparam int MF_CTYPE = 4;
    localparam int MF_CLEN  = 5;
    localparam int MF_MEDIA = 6;
    localparam int MF_LONG  = 7;

    localparam logic [7:0] MF_RESET = 8'h7F;

    // Targets longer than this report uri long
    localparam logic [11:0] URI_LIMIT = 12'd2048;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Strings, first character in the top byte
    localparam logic [8*4-1:0]  K_POST  = "POST";
    localparam logic [8*8-1:0]  K_V11   = "HTTP/1.1";
    localparam logic [8*8-1:0]  K_V10   = "HTTP/1.0";
    localparam logic [8*12-1:0] K_CTYPE = "Content-Type";
    localparam logic [8*14-1:0] K_CLEN  = "Content-Length";
    localparam logic [8*23-1:0] K_MEDIA = "application/dns-message";

    // Parse state carried from byte to byte
    typedef struct packed {
        t_phase          phase;
        logic [HC_W-1:0] header_count;
        logic            prev_cr;
        logic [11:0]     field_pos;
        logic [7:0]      match_flags;
        t_hkind          name_kind;
        logic [63:0]     length_value;
        logic            length_ovf;
        logic [1:0]      seen;
        t_status         first_error;
        logic [15:0]     body_rem;
    } t_state;

    // One result word
    typedef struct packed {
        logic        kind;
        t_status     status;
        logic [12:0] header_length;
        logic [15:0] body_length;
        logic [7:0]  body_byte;
        logic        last;
    } t_result;

    function automatic t_state reset_state();
        t_state s;
        s = '0;
        s.phase       = PH_METHOD;
        s.match_flags = MF_RESET;
        s.name_kind   = HK_NONE;
        s.first_error = ST_OK;
        return s;
    endfunction

    function automatic logic [7:0] lower8(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT);
    endfunction

    function automatic logic [11:0] bump(logic [11:0] p);
        return (p != 12'hFFF) ? p + 12'd1 : p;
    endfunction

    // Case-insensitive compare that fails outside the string
    function automatic logic chk(logic [7:0] b, logic [7:0] want, logic in_range);
        return in_range && (lower8(b) == lower8(want));
    endfunction

endpackage

// ===== sv/doh_request_header_parser_top.sv =====
// Request header parser for DNS-over-HTTPS POST requests. Unless the input
// stalls, one request byte is taken per cycle and parsed while held in the
// input register, a sustained rate of one byte per clock; the verdict or body
// byte is then registered in the result register. While a result waits under
// stall, the input register holds one more byte before the input stalls. The
// user must set the path match through the configuration port only while the
// block is idle; the block does not enforce this. Writes are always accepted.
// ----------------------------------------------------------------------------
// doh_request_header_parser_top
// Byte-serial HTTP request header checker with body pass-through.
// ----------------------------------------------------------------------------
module doh_request_header_parser_top #(
    parameter int MAX_HEADER_BYTES = 4096,
    parameter int MAX_BODY_BYTES   = 65535,
    parameter int MIN_BODY_BYTES   = 12,
    parameter int PATH_BYTES       = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_start_req,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [3:0]  o_status,
    output logic [12:0] o_header_length,
    output logic [15:0] o_body_length,
    output logic [7:0]  o_body_byte,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import dohp_pkg::*;

    logic [63:0] r_path_low;
    logic [63:0] r_path_high;
    logic [4:0]  r_path_len;

    logic        r_in_valid;
    logic        r_in_start;
    logic [7:0]  r_in_data;

    t_state      r_state;
    t_state      n_state;
    logic        res_valid;
    t_result     res;
    logic        r_out_valid;
    t_result     r_out;

    logic        advance;
    logic        in_take;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_low  <= 64'd0;
            r_path_high <= 64'd0;
            r_path_len  <= 5'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATH_LOW:  r_path_low  <= i_cfg_data;
                CFG_PATH_HIGH: r_path_high <= i_cfg_data;
                CFG_PATH_LEN:  r_path_len  <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Advance when the result register is free or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // Hold one input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_start <= i_start_req;
            r_in_data  <= i_data;
        end
    end

    dohp_step #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .MAX_BODY_BYTES   (MAX_BODY_BYTES),
        .MIN_BODY_BYTES   (MIN_BODY_BYTES),
        .PATH_BYTES       (PATH_BYTES)
    ) u_step (
        .i_state     (r_state),
        .i_path_low  (r_path_low),
        .i_path_high (r_path_high),
        .i_path_len  (r_path_len),
        .i_start     (r_in_start),
        .i_data      (r_in_data),
        .o_state     (n_state),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Update parse state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= reset_state();
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_status        = r_out.status;
    assign o_header_length = r_out.header_length;
    assign o_body_length   = r_out.body_length;
    assign o_body_byte     = r_out.body_byte;
    assign o_last          = r_out.last;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    a_body_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind) |->
        (r_out.status == ST_OK && r_out.header_length == 13'd0
         && r_out.body_length == 16'd0))
        else $error("body word carries verdict fields");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.kind && r_out.status != ST_OK) |-> r_out.last)
        else $error("error verdict without last");

    a_body_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_BODY) |-> (r_state.body_rem != 16'd0))
        else $error("body phase with nothing remaining");

    a_held_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_data)))
        else $error("held input word lost");
`endif

endmodule

// ===== sv/dohp_step.sv =====
// ----------------------------------------------------------------------------
// dohp_step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module dohp_step #(
    parameter int MAX_HEADER_BYTES = 4096,
    parameter int MAX_BODY_BYTES   = 65535,
    parameter int MIN_BODY_BYTES   = 12,
    parameter int PATH_BYTES       = 16
) (
    input  dohp_pkg::t_state  i_state,
    input  logic [63:0]       i_path_low,
    input  logic [63:0]       i_path_high,
    input  logic [4:0]        i_path_len,
    input  logic              i_start,
    input  logic [7:0]        i_data,
    output dohp_pkg::t_state  o_state,
    output logic              o_res_valid,
    output dohp_pkg::t_result o_res
);
    import dohp_pkg::*;

    logic [127:0] path_word;
    assign path_word = {i_path_high, i_path_low};

    function automatic t_state note_error(t_state s, t_status code);
        t_state r;
        r = s;
        if (r.first_error == ST_OK) begin
            r.first_error = code;
        end
        return r;
    endfunction

    function automatic t_state feed_ctype(t_state s, logic [7:0] b);
        t_state r;
        logic [11:0] p;
        r = s;
        p = s.field_pos;
        if (p == 12'd0 && is_ws(b)) begin
            r = s;
        end else if (p < 12'd23) begin
            if (lower8(b) != K_MEDIA[8*(22-p[4:0]) +: 8]) begin
                r.match_flags[MF_MEDIA] = 1'b0;
            end
            r.field_pos = p + 12'd1;
        end else if (p == 12'd23) begin
            if (b == CH_SEMI) begin
                r.field_pos = 12'd24;
            end else if (is_ws(b)) begin
                r.field_pos = 12'd25;
            end else begin
                r.match_flags[MF_MEDIA] = 1'b0;
            end
        end else if (p == 12'd25) begin
            if (!is_ws(b)) begin
                r.match_flags[MF_MEDIA] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic t_state feed_clen(t_state s, logic [7:0] b);
        t_state r;
        logic [11:0] p;
        logic [67:0] prod;
        r = s;
        p = s.field_pos;
        prod = ({4'd0, s.length_value} << 3) + ({4'd0, s.length_value} << 1)
               + {64'd0, b[3:0] - 4'd0};
        if ((b >= 8'h30 && b <= 8'h39) && (p == 12'd0 || p == 12'd1)) begin
            // Accumulate one decimal digit, flag overflow past 64 bits
            if (!s.length_ovf) begin
                if (prod[67:64] != 4'd0) begin
                    r.length_ovf = 1'b1;
                end else begin
                    r.length_value = prod[63:0];
                end
            end
            r.field_pos = 12'd1;
        end else if (is_ws(b)) begin
            if (p == 12'd1) begin
                r.field_pos = 12'd2;
            end
        end else begin
            r.field_pos = 12'd3;
        end
        return r;
    endfunction

    function automatic t_state feed(t_state s, logic [7:0] b);
        t_state r;
        logic [11:0] p;
        r = s;
        p = s.field_pos;
        unique case (s.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    if (!(s.match_flags[MF_POST] && p == 12'd4)) begin
                        r.match_flags[MF_POST] = 1'b0;
                    end
                    r.phase = PH_TARGET;
                    r.field_pos = 12'd0;
                    r.match_flags[MF_PATH] = 1'b1;
                end else begin
                    r.match_flags[MF_POST] = s.match_flags[MF_POST]
                        & chk(b, K_POST[8*(3-p[1:0]) +: 8], p < 12'd4);
                    r.field_pos = bump(p);
                end
            end
            PH_TARGET: begin
                if (b == CH_SP) begin
                    if (p == 12'd0) begin
                        r = note_error(r, ST_BAD_REQUEST);
                    end
                    if (p != {7'd0, i_path_len}) begin
                        r.match_flags[MF_PATH] = 1'b0;
                    end
                    r.match_flags[MF_LONG] = (p > URI_LIMIT);
                    r.phase = PH_VERSION;
                    r.field_pos = 12'd0;
                    r.match_flags[MF_V11] = 1'b1;
                    r.match_flags[MF_V10] = 1'b1;
                end else begin
                    if (!(p < {7'd0, i_path_len} && p < 12'(PATH_BYTES)
                          && b == path_word[8*p[3:0] +: 8])) begin
                        r.match_flags[MF_PATH] = 1'b0;
                    end
                    r.field_pos = bump(p);
                end
            end
            PH_VERSION: begin
                r.match_flags[MF_V11] = s.match_flags[MF_V11]
                    & chk(b, K_V11[8*(7-p[2:0]) +: 8], p < 12'd8);
                r.match_flags[MF_V10] = s.match_flags[MF_V10]
                    & chk(b, K_V10[8*(7-p[2:0]) +: 8], p < 12'd8);
                r.field_pos = bump(p);
            end
            PH_HNAME: begin
                if (b == CH_COLON) begin
                    if (s.match_flags[MF_CTYPE] && p == 12'd12) begin
                        r.name_kind = HK_CTYPE;
                    end else if (s.match_flags[MF_CLEN] && p == 12'd14) begin
                        r.name_kind = HK_CLEN;
                        r.length_value = 64'd0;
                        r.length_ovf = 1'b0;
                    end else begin
                        r.name_kind = HK_NONE;
                    end
                    r.match_flags[MF_MEDIA] = 1'b1;
                    r.phase = PH_HVALUE;
                    r.field_pos = 12'd0;
                end else begin
                    r.match_flags[MF_CTYPE] = s.match_flags[MF_CTYPE]
                        & chk(b, K_CTYPE[8*(11-p[3:0]) +: 8], p < 12'd12);
                    r.match_flags[MF_CLEN] = s.match_flags[MF_CLEN]
                        & chk(b, K_CLEN[8*(13-p[3:0]) +: 8], p < 12'd14);
                    r.field_pos = bump(p);
                end
            end
            PH_HVALUE: begin
                if (s.name_kind == HK_CTYPE) begin
                    r = feed_ctype(s, b);
                end else if (s.name_kind == HK_CLEN) begin
                    r = feed_clen(s, b);
                end
            end
            default: begin
                r = s;
            end
        endcase
        return r;
    endfunction

    // Close a line on CR LF
    function automatic t_state finish_line(t_state s);
        t_state r;
        logic [11:0] p;
        r = s;
        p = s.field_pos;
        unique case (s.phase)
            PH_METHOD, PH_TARGET: begin
                r = note_error(r, ST_BAD_REQUEST);
            end
            PH_VERSION: begin
                if (p == 12'd0) begin
                    r = note_error(r, ST_BAD_REQUEST);
                end else if (!s.match_flags[MF_POST]) begin
                    r = note_error(r, ST_METHOD);
                end else if (!s.match_flags[MF_PATH]) begin
                    r = note_error(r, s.match_flags[MF_LONG] ? ST_URI_LONG : ST_NOT_FOUND);
                end else if (!(p == 12'd8 && (s.match_flags[MF_V11] || s.match_flags[MF_V10])))
                begin
                    r = note_error(r, ST_VERSION);
                end
            end
            PH_HNAME: begin
                r = note_error(r, ST_BAD_REQUEST);
            end
            PH_HVALUE: begin
                if (s.name_kind == HK_CTYPE) begin
                    r.seen[0] = s.match_flags[MF_MEDIA] && (p >= 12'd23);
                end else if (s.name_kind == HK_CLEN) begin
                    if (s.seen[1] || p == 12'd0 || p == 12'd3 || s.length_ovf) begin
                        r = note_error(r, ST_BAD_REQUEST);
                    end else begin
                        r.seen[1] = 1'b1;
                    end
                end
            end
            default: begin
                r = s;
            end
        endcase
        r.phase = PH_HNAME;
        r.field_pos = 12'd0;
        r.name_kind = HK_NONE;
        r.match_flags[MF_CTYPE] = 1'b1;
        r.match_flags[MF_CLEN] = 1'b1;
        return r;
    endfunction

    t_state  s0;
    t_state  s1;
    t_state  s2;
    t_state  n_state;
    t_status verdict;
    logic    ended;

    // Clear on a new request
    assign s0 = i_start ? reset_state() : i_state;
    assign ended = s0.prev_cr && (i_data == CH_LF) && (s0.phase == PH_HNAME)
                   && (s0.field_pos == 12'd0);

    // Run the held CR, then the new byte
    always_comb begin
        s1 = s0;
        s1.header_count = s0.header_count + HC_W'(1);
        s1.prev_cr = (i_data == CH_CR);
        if (s0.prev_cr && i_data == CH_LF) begin
            if (!ended) begin
                s2 = finish_line(s1);
            end else begin
                s2 = s1;
            end
        end else begin
            if (s0.prev_cr) begin
                s2 = feed(s1, CH_CR);
            end else begin
                s2 = s1;
            end
            if (i_data != CH_CR) begin
                s2 = feed(s2, i_data);
            end
        end
    end

    // End-of-header checks in priority order
    always_comb begin
        verdict = s2.first_error;
        if (verdict == ST_OK) begin
            priority if (!s2.seen[0]) begin
                verdict = ST_MEDIA;
            end else if (!s2.seen[1]) begin
                verdict = ST_LENGTH_REQ;
            end else if (s2.length_value > 64'(MAX_BODY_BYTES)) begin
                verdict = ST_TOO_LARGE;
            end else if (s2.length_value < 64'(MIN_BODY_BYTES)) begin
                verdict = ST_BAD_REQUEST;
            end else begin
                verdict = ST_OK;
            end
        end
    end

    // Select the result and the next state
    always_comb begin
        n_state = s0;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.status = ST_OK;
        if (s0.phase == PH_DONE) begin
            n_state = s0;
        end else if (s0.phase == PH_BODY) begin
            o_res_valid = 1'b1;
            o_res.kind = 1'b1;
            o_res.body_byte = i_data;
            o_res.last = (s0.body_rem <= 16'd1);
            if (s0.body_rem != 16'd0) begin
                n_state.body_rem = s0.body_rem - 16'd1;
            end
            if (s0.body_rem <= 16'd1) begin
                n_state.phase = PH_DONE;
            end
        end else begin
            n_state = s2;
            if (ended) begin
                o_res_valid = 1'b1;
                if (verdict == ST_OK) begin
                    n_state.body_rem = s2.length_value[15:0];
                    n_state.phase = (s2.length_value[15:0] != 16'd0) ? PH_BODY : PH_DONE;
                    o_res.header_length = s2.header_count[12:0];
                    o_res.body_length = s2.length_value[15:0];
                end else begin
                    n_state.phase = PH_DONE;
                    o_res.status = verdict;
                    o_res.last = 1'b1;
                end
            end else if (s2.header_count >= HC_W'(MAX_HEADER_BYTES)) begin
                o_res_valid = 1'b1;
                n_state.phase = PH_DONE;
                o_res.status = ST_HEADER_BIG;
                o_res.last = 1'b1;
            end
        end
    end

    assign o_state = n_state;

endmodule

// ===== bench/tb_doh_request_header_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_doh_request_header_parser_top
// Streams HTTP requests, mostly POST, byte by byte into the header parser,
// predicts every verdict and body word with a local parser model, and checks
// each result word field by field, mostly under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_doh_request_header_parser_top;
    import dohp_pkg::*;

    localparam int HDR_LIMIT  = 4096;
    localparam int BODY_MAX   = 65535;
    localparam int BODY_MIN   = 12;
    localparam int PATH_MAX   = 16;
    localparam int URI_MAX    = 2048;
    localparam int CYCLE_CAP  = 800000;
    localparam int SETTLE     = 8;

    typedef struct {
        bit         start;
        logic [7:0] data;
    } t_byte_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_start_req;
    logic [7:0]  i_data;
    logic        o_valid;
    logic        i_stall;
    logic        o_kind;
    logic [3:0]  o_status;
    logic [12:0] o_header_length;
    logic [15:0] o_body_length;
    logic [7:0]  o_body_byte;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    doh_request_header_parser_top DUT (.*);

    // Pending request bytes, expected result words, request under construction
    t_byte_word byte_feed[$];
    t_result    expected_words[$];
    logic [7:0] req_bytes[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  calm = 0;
    int  feed_gap = 0;
    int  stall_left = 0;

    // Model copy of the path registers and the parse state
    logic [63:0] path_low_q;
    logic [63:0] path_high_q;
    logic [4:0]  path_len_q;

    t_phase      ps_phase;
    int unsigned ps_hcount;
    logic [7:0]  ps_last_byte;
    int unsigned ps_pos;
    logic [7:0]  ps_flags;
    t_hkind      ps_kind;
    logic [63:0] ps_len_val;
    bit          ps_len_ovf;
    logic [1:0]  ps_seen;
    t_status     ps_err;
    int unsigned ps_body_left;

    // Path bytes the generator targets in the current phase
    logic [7:0] gen_path[PATH_MAX];
    int         gen_plen;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------- model
    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == CH_SP || c == CH_HT;
    endfunction

    function automatic int unsigned step_pos(int unsigned p);
        return p < 4095 ? p + 1 : p;
    endfunction

    function automatic void clear_parse();
        ps_phase     = PH_METHOD;
        ps_hcount    = 0;
        ps_last_byte = 8'h00;
        ps_pos       = 0;
        ps_flags     = MF_RESET;
        ps_kind      = HK_NONE;
        ps_len_val   = '0;
        ps_len_ovf   = 0;
        ps_seen      = '0;
        ps_err       = ST_OK;
        ps_body_left = 0;
    endfunction

    function automatic void flag_error(t_status code);
        if (ps_err == ST_OK) ps_err = code;
    endfunction

    function automatic void match_text(logic [7:0] b, string w, int unsigned n, int flag);
        if (ps_pos < n) begin
            if (fold_case(b) != fold_case(w[ps_pos])) ps_flags[flag] = 1'b0;
        end else begin
            ps_flags[flag] = 1'b0;
        end
    endfunction

    function automatic logic [7:0] path_char(int unsigned idx);
        return idx < 8 ? path_low_q[8*idx +: 8] : path_high_q[8*(idx-8) +: 8];
    endfunction

    function automatic void media_char(logic [7:0] b);
        string media;
        media = "application/dns-message";
        if (ps_pos == 0 && blank(b)) return;
        if (ps_pos < 23) begin
            if (fold_case(b) != media[ps_pos]) ps_flags[MF_MEDIA] = 1'b0;
            ps_pos++;
        end else if (ps_pos == 23) begin
            if (b == CH_SEMI) ps_pos = 24;
            else if (blank(b)) ps_pos = 25;
            else ps_flags[MF_MEDIA] = 1'b0;
        end else if (ps_pos == 25) begin
            if (!blank(b)) ps_flags[MF_MEDIA] = 1'b0;
        end
    endfunction

    function automatic void length_char(logic [7:0] b);
        logic [63:0] d;
        bit          dig;
        dig = b >= "0" && b <= "9";
        if (dig && ps_pos <= 1) begin
            d = 64'(b - "0");
            if (!ps_len_ovf) begin
                if (ps_len_val > ({64{1'b1}} - d) / 10) ps_len_ovf = 1;
                else ps_len_val = ps_len_val * 10 + d;
            end
            ps_pos = 1;
        end else if (blank(b)) begin
            if (ps_pos == 1) ps_pos = 2;
        end else begin
            ps_pos = 3;
        end
    endfunction

    function automatic void parse_char(logic [7:0] b);
        case (ps_phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    if (!(ps_flags[MF_POST] && ps_pos == 4)) ps_flags[MF_POST] = 1'b0;
                    ps_phase = PH_TARGET;
                    ps_pos = 0;
                    ps_flags[MF_PATH] = 1'b1;
                end else begin
                    match_text(b, "POST", 4, MF_POST);
                    ps_pos = step_pos(ps_pos);
                end
            end
            PH_TARGET: begin
                if (b == CH_SP) begin
                    if (ps_pos == 0) flag_error(ST_BAD_REQUEST);
                    if (ps_pos != path_len_q) ps_flags[MF_PATH] = 1'b0;
                    ps_flags[MF_LONG] = ps_pos > URI_MAX;
                    ps_phase = PH_VERSION;
                    ps_pos = 0;
                    ps_flags[MF_V11] = 1'b1;
                    ps_flags[MF_V10] = 1'b1;
                end else begin
                    if (ps_pos < path_len_q && ps_pos < PATH_MAX) begin
                        if (b != path_char(ps_pos)) ps_flags[MF_PATH] = 1'b0;
                    end else begin
                        ps_flags[MF_PATH] = 1'b0;
                    end
                    ps_pos = step_pos(ps_pos);
                end
            end
            PH_VERSION: begin
                match_text(b, "HTTP/1.1", 8, MF_V11);
                match_text(b, "HTTP/1.0", 8, MF_V10);
                ps_pos = step_pos(ps_pos);
            end
            PH_HNAME: begin
                if (b == CH_COLON) begin
                    if (ps_flags[MF_CTYPE] && ps_pos == 12) ps_kind = HK_CTYPE;
                    else if (ps_flags[MF_CLEN] && ps_pos == 14) ps_kind = HK_CLEN;
                    else ps_kind = HK_NONE;
                    if (ps_kind == HK_CLEN) begin
                        ps_len_val = '0;
                        ps_len_ovf = 0;
                    end
                    ps_flags[MF_MEDIA] = 1'b1;
                    ps_phase = PH_HVALUE;
                    ps_pos = 0;
                end else begin
                    match_text(b, "Content-Type", 12, MF_CTYPE);
                    match_text(b, "Content-Length", 14, MF_CLEN);
                    ps_pos = step_pos(ps_pos);
                end
            end
            PH_HVALUE: begin
                if (ps_kind == HK_CTYPE) media_char(b);
                else if (ps_kind == HK_CLEN) length_char(b);
            end
            default: ;
        endcase
    endfunction

    // Close a line at CR LF; return 1 on the blank line that ends the header
    function automatic bit close_line();
        case (ps_phase)
            PH_METHOD, PH_TARGET: flag_error(ST_BAD_REQUEST);
            PH_VERSION: begin
                if (ps_pos == 0) flag_error(ST_BAD_REQUEST);
                else if (!ps_flags[MF_POST]) flag_error(ST_METHOD);
                else if (!ps_flags[MF_PATH])
                    flag_error(ps_flags[MF_LONG] ? ST_URI_LONG : ST_NOT_FOUND);
                else if (!(ps_pos == 8 && (ps_flags[MF_V11] || ps_flags[MF_V10])))
                    flag_error(ST_VERSION);
            end
            PH_HNAME: begin
                if (ps_pos == 0) return 1;
                flag_error(ST_BAD_REQUEST);
            end
            PH_HVALUE: begin
                if (ps_kind == HK_CTYPE) begin
                    ps_seen[0] = ps_flags[MF_MEDIA] && ps_pos >= 23;
                end else if (ps_kind == HK_CLEN) begin
                    if (ps_seen[1] || ps_pos == 0 || ps_pos == 3 || ps_len_ovf)
                        flag_error(ST_BAD_REQUEST);
                    else
                        ps_seen[1] = 1'b1;
                end
            end
            default: ;
        endcase
        ps_phase = PH_HNAME;
        ps_pos = 0;
        ps_kind = HK_NONE;
        ps_flags[MF_CTYPE] = 1'b1;
        ps_flags[MF_CLEN] = 1'b1;
        return 0;
    endfunction

    // Advance the parser by one accepted word; return 1 if it yields a result
    function automatic bit parse_byte(bit start, logic [7:0] b, output t_result r);
        bit      prev_cr;
        bit      ended;
        t_status st;
        r = '0;
        ended = 0;
        if (start) clear_parse();
        if (ps_phase == PH_DONE) return 0;
        if (ps_phase == PH_BODY) begin
            r.kind = 1'b1;
            r.body_byte = b;
            r.last = ps_body_left <= 1;
            if (ps_body_left > 0) ps_body_left--;
            if (ps_body_left == 0) ps_phase = PH_DONE;
            return 1;
        end
        ps_hcount++;
        prev_cr = ps_last_byte == CH_CR;
        ps_last_byte = b;
        if (prev_cr && b == CH_LF) begin
            ended = close_line();
        end else begin
            if (prev_cr) parse_char(CH_CR);
            if (b != CH_CR) parse_char(b);
        end
        if (ended) begin
            st = ps_err;
            if (st == ST_OK) begin
                if (!ps_seen[0]) st = ST_MEDIA;
                else if (!ps_seen[1]) st = ST_LENGTH_REQ;
                else if (ps_len_val > BODY_MAX) st = ST_TOO_LARGE;
                else if (ps_len_val < BODY_MIN) st = ST_BAD_REQUEST;
            end
            if (st == ST_OK) begin
                ps_body_left = ps_len_val[15:0];
                r.header_length = 13'(ps_hcount);
                r.body_length = ps_len_val[15:0];
                ps_phase = ps_body_left != 0 ? PH_BODY : PH_DONE;
            end else begin
                r.status = st;
                r.last = 1'b1;
                ps_phase = PH_DONE;
            end
            return 1;
        end
        if (ps_hcount >= HDR_LIMIT) begin
            r.status = ST_HEADER_BIG;
            r.last = 1'b1;
            ps_phase = PH_DONE;
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------ request builder
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
    endtask

    task automatic add_crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endtask

    task automatic add_random(int n);
        repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Move the built request into the feed, start flag on its first byte
    task automatic queue_request();
        t_byte_word w;
        foreach (req_bytes[i]) begin
            w.start = i == 0;
            w.data = req_bytes[i];
            byte_feed.push_back(w);
        end
        req_bytes.delete();
    endtask

    function automatic string mixcase(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1)) t[i] = t[i] - 8'd32;
            else if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(0, 1)) t[i] = t[i] + 8'd32;
        return t;
    endfunction

    task automatic add_target(int sel);
        int n;
        n = gen_plen;
        if (sel < 78) begin
            for (int i = 0; i < n; i++) req_bytes.push_back(gen_path[i]);
        end else if (sel < 84) begin
            for (int i = 0; i < n; i++)
                req_bytes.push_back(i == n - 1 ? gen_path[i] ^ 8'h01 : gen_path[i]);
        end else if (sel < 88) begin
            for (int i = 0; i < n; i++) req_bytes.push_back(gen_path[i]);
            add_text("x");
        end else if (sel < 92) begin
            // empty target
        end else if (sel < 95) begin
            for (int i = 0; i < n - 1; i++) req_bytes.push_back(gen_path[i]);
        end else if (sel < 97) begin
            repeat ($urandom_range(17, 40)) add_text("a");
        end else begin
            repeat ($urandom_range(1, 20)) req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    // One request: mostly well formed with random content and spelling,
    // with some malformed lines, values, versions and truncated bodies
    task automatic random_request();
        string heads[$];
        string s;
        int    blen;
        int    r;
        if ($urandom_range(0, 19) == 0) begin
            add_random($urandom_range(1, 30));
            queue_request();
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 85) add_text(mixcase("POST"));
        else if (r < 89) add_text("GET");
        else if (r < 93) add_text("POSTT");
        else if (r < 96) add_text("POS");
        else if (r < 98) add_text("");
        else add_random(2);
        add_text(" ");
        add_target($urandom_range(0, 99));
        add_text(" ");
        r = $urandom_range(0, 99);
        if (r < 85) add_text(mixcase($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0"));
        else if (r < 91) add_text("HTTP/2.0");
        else if (r < 96) add_text("HTTP/1.10");
        add_crlf();

        // Content-Type header line
        r = $urandom_range(0, 99);
        if (r < 92) begin
            case ($urandom_range(0, 9))
                0: s = "Content-Typ";
                1: s = "Content-Types";
                default: s = mixcase("Content-Type");
            endcase
            s = {s, ":"};
            case ($urandom_range(0, 13))
                0: s = {s, " application/dns-message; charset=x"};
                1: s = {s, " \t application/dns-message \t"};
                2: s = {s, " application/dns-messages"};
                3: s = {s, " application/json"};
                4: s = {s, ""};
                5: s = {s, " application/dns-message ;x"};
                6: s = {s, "application/dns-message;"};
                default: s = {s, " ", mixcase("application/dns-message")};
            endcase
            heads.insert($urandom_range(0, heads.size()), s);
        end

        // Content-Length header line, with the body size to send
        blen = $urandom_range(12, 40);
        case ($urandom_range(0, 19))
            0: begin blen = $urandom_range(0, 11); s = $sformatf("%0d", blen); end
            1: begin blen = 6; s = "65535"; end
            2: begin blen = 0; s = "65536"; end
            3: begin blen = 0; s = "99999999999999999999999"; end
            4: begin blen = 0; s = "18446744073709551615"; end
            5: s = $sformatf(" \t%0d \t", blen);
            6: begin s = "1 8"; blen = 18; end
            7: begin s = "1a"; blen = 3; end
            8: begin s = ""; blen = 3; end
            default: s = $sformatf(" %0d", blen);
        endcase
        if ($urandom_range(0, 19) != 0)
            heads.insert($urandom_range(0, heads.size()),
                         {mixcase("Content-Length"), ":", s});
        if ($urandom_range(0, 24) == 0)
            heads.insert($urandom_range(0, heads.size()), "Content-Length: 20");
        if ($urandom_range(0, 3) == 0)
            heads.insert($urandom_range(0, heads.size()), "Host: example");
        if ($urandom_range(0, 29) == 0)
            heads.insert($urandom_range(0, heads.size()), "Bogus line");
        foreach (heads[i]) begin
            add_text(heads[i]);
            add_crlf();
        end
        if ($urandom_range(0, 5) == 0) begin
            // lone CR and LF inside a value, and a NUL
            add_text("X-Odd: a");
            req_bytes.push_back(CH_CR);
            add_text("b");
            req_bytes.push_back(CH_LF);
            req_bytes.push_back(8'h00);
            add_crlf();
        end
        add_crlf();
        if ($urandom_range(0, 15) == 0) blen = $urandom_range(0, blen);
        else if ($urandom_range(0, 7) == 0) blen += $urandom_range(1, 4);
        add_random(blen);
        queue_request();
    endtask

    // A well formed request aimed at the current path
    task automatic good_request(string ver, int blen);
        add_text("POST ");
        for (int i = 0; i < gen_plen; i++) req_bytes.push_back(gen_path[i]);
        add_text({" ", ver});
        add_crlf();
        add_text("Content-Type: application/dns-message");
        add_crlf();
        add_text($sformatf("Content-Length: %0d", blen));
        add_crlf();
        add_crlf();
        add_random(blen);
        queue_request();
    endtask

    // ------------------------------------------------------------ config port
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PATH_LOW:  path_low_q  = value;
            CFG_PATH_HIGH: path_high_q = value;
            CFG_PATH_LEN:  path_len_q  = value[4:0];
            default: ;
        endcase
    endtask

    // Load a path into the block; the generator aims at its first bytes
    task automatic set_path(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word);
        write_reg(CFG_PATH_LOW, lo);
        write_reg(CFG_PATH_HIGH, hi);
        write_reg(CFG_PATH_LEN, len_word);
        gen_plen = (len_word[4:0] == 0) ? 1 : (len_word[4:0] > PATH_MAX ? PATH_MAX : len_word[4:0]);
        for (int i = 0; i < PATH_MAX; i++)
            gen_path[i] = i < 8 ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    endtask

    function automatic logic [63:0] printable_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
        return w;
    endfunction

    // Wait until all words are sent and answered, then let the pipe drain
    task automatic drain();
        do @(posedge i_clk);
        while (byte_feed.size() != 0 || i_valid || expected_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------ driver
    always @(posedge i_clk) begin
        t_result    r;
        t_byte_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // predict on every accepted word
            if (i_valid && !o_stall) begin
                if (parse_byte(i_start_req, i_data, r)) expected_words.push_back(r);
            end
            // advance when the word moved or the line is empty
            if (!i_valid || !o_stall) begin
                if (feed_gap > 0) begin
                    feed_gap <= feed_gap - 1;
                    i_valid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    w = byte_feed.pop_front();
                    i_valid <= 1'b1;
                    i_start_req <= w.start;
                    i_data <= w.data;
                    if (!calm && $urandom_range(0, 15) == 0) feed_gap <= $urandom_range(1, 11);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------ monitor
    task automatic report(string field, longint want, longint got);
        $display("mismatch at cycle %0d: %s expected %0d got %0d",
                 cycle_count, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word, kind", -1, o_kind);
                end else begin
                    e = expected_words.pop_front();
                    if (o_kind !== e.kind) report("kind", e.kind, o_kind);
                    if (o_status !== e.status) report("status", e.status, o_status);
                    if (o_header_length !== e.header_length)
                        report("header_length", e.header_length, o_header_length);
                    if (o_body_length !== e.body_length)
                        report("body_length", e.body_length, o_body_length);
                    if (o_body_byte !== e.body_byte)
                        report("body_byte", e.body_byte, o_body_byte);
                    if (o_last !== e.last) report("last", e.last, o_last);
                end
            end
            // hold stall in random bursts
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 12) == 0) begin
                stall_left <= $urandom_range(0, 10);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_doh_request_header_parser_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------ sequence
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_start_req = 1'b0;
        i_data = 8'h00;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PATH_LOW;
        i_cfg_data = '0;
        path_low_q = '0;
        path_high_q = '0;
        path_len_q = 5'd1;
        clear_parse();
        gen_plen = 1;
        foreach (gen_path[i]) gen_path[i] = 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset path: a single NUL byte
        good_request("HTTP/1.1", 12);
        add_text("GET ");
        req_bytes.push_back(8'h00);
        add_text(" HTTP/1.1");
        add_crlf();
        add_crlf();
        queue_request();
        drain();

        // Full sixteen byte path
        set_path(printable_word(), printable_word(), 64'd16);
        good_request("http/1.0", 12);
        // start in the middle of a body cuts it short
        byte_feed = byte_feed[0:byte_feed.size()-6];
        random_request();
        drain();

        // Short path
        set_path(printable_word(), printable_word(), $urandom_range(1, 15));
        random_request();
        drain();

        // Zero length never matches; unused index is ignored
        set_path(printable_word(), {64{1'b1}}, 64'd0);
        write_reg(2'd3, {64{1'b1}});
        random_request();
        drain();

        // Length above the path width, all-ones registers
        set_path({64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        random_request();
        drain();

        // Final stretch without idling on either side
        set_path(printable_word(), printable_word(), $urandom_range(1, 16));
        calm = 1;
        random_request();
        drain();
        repeat (SETTLE) @(posedge i_clk);

        if (error_count == 0 && expected_words.size() == 0) begin
            $display("tb_doh_request_header_parser_top: PASS");
        end else begin
            $display("tb_doh_request_header_parser_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dohp_pkg.sv
sv/dohp_step.sv
sv/doh_request_header_parser_top.sv
bench/tb_doh_request_header_parser_top.sv
